// ----- src/wgm_pkg.sv -----
// ============================================================================
// wgm_pkg - shared types and constants of the wildcard glob matcher
// Holds the request kind codes, the wildcard byte codes and the structs
// that run between the top level and the matcher cells.
// ============================================================================
`default_nettype none

package wgm_pkg;

   // Default pattern capacity in bytes.
   localparam int PAT_MAX_DEF = 64;

   // Wildcard bytes.
   localparam logic [7:0] CH_STAR  = 8'd42;
   localparam logic [7:0] CH_QUEST = 8'd63;

   // Request kinds, carried on req_tuser.
   localparam logic [1:0] REQ_CLEAR   = 2'd0;
   localparam logic [1:0] REQ_APPEND  = 2'd1;
   localparam logic [1:0] REQ_SUBJECT = 2'd2;
   localparam logic [1:0] REQ_END     = 2'd3;

   // Broadcast from the top level to every cell.
   typedef struct packed {
      logic       restart;  // return the active set to position zero only
      logic       step;     // advance the active set by one subject byte
      logic       append;   // store ch in the cell at the current length
      logic [7:0] ch;       // pattern or subject byte
   } cell_ctrl_type;

   // Handed from one cell to the next.
   typedef struct packed {
      logic carry;  // star closure reaches the next position
      logic adv;    // this byte moves the match into the next position
   } cell_link_type;

endpackage

`default_nettype wire

// ----- src/wgm_cell.sv -----
// ============================================================================
// wgm_cell - one pattern position of the glob matcher
// Holds one pattern byte and the active bit of its position, closes the
// active set through a star and advances it by one subject byte.
// ============================================================================
`default_nettype none

module wgm_cell #(
   parameter int PAT_MAX = wgm_pkg::PAT_MAX_DEF,
   parameter int IDX     = 0,
   parameter int LEN_W   = $clog2(PAT_MAX + 1)
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wgm_pkg::cell_ctrl_type      ctrl,
   input  wire  [LEN_W-1:0]            len,
   input  wgm_pkg::cell_link_type      link_in,
   output wgm_pkg::cell_link_type      link_out,
   output logic                        hit
);
   import wgm_pkg::*;

   localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(IDX);

   logic [7:0] ch_ff;
   logic       act_ff;
   logic       act_in;
   logic       en;
   logic       is_end;
   logic       closed;
   logic       is_star;
   logic       is_hit;

   assign en      = (len > MY_IDX);
   assign is_end  = (len == MY_IDX);
   assign closed  = act_ff | link_in.carry;
   assign is_star = (ch_ff == CH_STAR);
   assign is_hit  = (ch_ff == CH_QUEST) || (ch_ff == ctrl.ch);

   assign link_out.carry = en & closed & is_star;
   assign link_out.adv   = en & closed & ~is_star & is_hit;
   assign hit            = is_end & closed;

   always_comb begin
      act_in = act_ff;
      if (ctrl.restart) begin
         act_in = (IDX == 0);
      end else if (ctrl.step) begin
         // a star keeps its own position, a match fills the next one
         act_in = (en & closed & is_star) | link_in.adv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= (IDX == 0);
      end else begin
         act_ff <= act_in;
      end
   end

   // pattern byte: written once per append, no reset
   always_ff @(posedge clock) begin
      if (ctrl.append && is_end) begin
         ch_ff <= ctrl.ch;
      end
   end

endmodule

`default_nettype wire

// ----- src/wildcard_glob_matcher_core.sv -----
// The response beat is registered and is offered in the cycle after its end-of-subject beat.
// Throughput: one request beat per cycle for every request kind, unless a held response beat stalls req_tready.
// The cycle time is set by the star closure rippling through the cell chain.
// Reset: pattern length and overflow flag clear, active set is position zero.
// Pattern bytes stay undefined until appended; no clearing pass is needed.
// ============================================================================
// wildcard_glob_matcher_core - streaming glob matcher with '*' and '?'
// Loads a pattern byte by byte into a chain of cells, then runs subject
// bytes through the chain as a bit-parallel automaton and reports a match
// on each end-of-subject beat.
// ============================================================================
`default_nettype none

module wildcard_glob_matcher_core #(
   parameter int PAT_MAX = wgm_pkg::PAT_MAX_DEF
) (
   input  wire        clock,
   input  wire        reset,
   // request channel
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] char_in
   input  wire  [1:0] req_tuser,   // [1:0] req_type
   // response channel
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);
   import wgm_pkg::*;

   localparam int LEN_W = $clog2(PAT_MAX + 1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PAT_MAX);

   // ---------------------------------------------------------------------
   // Handshake: the response register parts the two sides, so take a new
   // request whenever that register is empty or drains in this cycle.
   // ---------------------------------------------------------------------
   logic       req_fire;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Pattern length and overflow flag
   // ---------------------------------------------------------------------
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic             full;

   assign full = (len_ff == LEN_MAX);

   // decode the beat into the broadcast to the cells
   cell_ctrl_type ctrl;

   always_comb begin
      ctrl.restart = 1'b0;
      ctrl.step    = 1'b0;
      ctrl.append  = 1'b0;
      ctrl.ch      = req_tdata;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      if (req_fire) begin
         case (req_tuser)
            REQ_CLEAR: begin
               ctrl.restart = 1'b1;
               len_in       = '0;
               ovf_in       = 1'b0;
            end
            REQ_APPEND: begin
               // append restarts matching; drop the byte once full
               ctrl.restart = 1'b1;
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  ctrl.append = 1'b1;
                  len_in      = len_ff + LEN_W'(1);
               end
            end
            REQ_SUBJECT: begin
               ctrl.step = 1'b1;
            end
            REQ_END: begin
               ctrl.restart = 1'b1;
            end
            default: begin
               ctrl.restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         ovf_ff <= ovf_in;
      end
   end

   // ---------------------------------------------------------------------
   // Cell chain: one cell per pattern position plus one for the final
   // position, which never stores a byte and only collects the match.
   // ---------------------------------------------------------------------
   cell_link_type        links [0:PAT_MAX+1];
   logic [PAT_MAX:0]     hits;
   logic                 hit_any;

   assign links[0] = '0;

   for (genvar i = 0; i <= PAT_MAX; i++) begin : g_cell
      wgm_cell #(
         .PAT_MAX (PAT_MAX),
         .IDX     (i),
         .LEN_W   (LEN_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .len      (len_ff),
         .link_in  (links[i]),
         .link_out (links[i+1]),
         .hit      (hits[i])
      );
   end

   // exactly the cell at the pattern length reports the match
   assign hit_any = |hits;

   // ---------------------------------------------------------------------
   // Response register: load on an end-of-subject beat, drop on handoff
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_fire && (req_tuser == REQ_END)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'b0, ovf_ff, hit_any};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // the final cell never holds a byte, so nothing leaves the chain
   a_tail_quiet : assert property (@(posedge clock) disable iff (reset)
      (links[PAT_MAX+1] == '0))
      else $error("link out of the final cell is active");

   // at most one cell sits at the pattern length
   a_hit_single : assert property (@(posedge clock) disable iff (reset)
      $onehot0(hits))
      else $error("more than one cell reports a match");

   // the length never passes the capacity
   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      (len_ff <= LEN_MAX))
      else $error("pattern length beyond capacity");

   // a clear beat empties the pattern and drops the overflow flag
   a_clear : assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == REQ_CLEAR)) |=> ((len_ff == '0) && !ovf_ff))
      else $error("clear did not empty the pattern");

endmodule

`default_nettype wire

// ----- sim/wildcard_glob_matcher_core_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// wildcard_glob_matcher_core_test - self-checking bench for the glob matcher
// Loads patterns of '*', '?' and literal bytes, streams subjects against
// them and checks every end-of-subject response beat against an in-bench
// automaton model. The sender runs in bursts with gaps, and the receiver
// stalls on its own pattern, including one long hold-off.
// ============================================================================
`default_nettype none

module wildcard_glob_matcher_core_test;

   import wgm_pkg::*;

   localparam int PAT_MAX     = PAT_MAX_DEF;
   localparam int ITEM_TARGET = 1700;
   localparam int CYCLE_LIMIT = 150000;
   localparam int DRAIN_WAIT  = 20;
   localparam int HOLD_AFTER  = 400;   // beats taken before the long hold-off
   localparam int HOLD_LEN    = 300;   // cycles of the long hold-off

   // active set with only position zero live
   localparam logic [PAT_MAX:0] START_SET = {{PAT_MAX{1'b0}}, 1'b1};

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] ch;
   } glob_beat_type;

   typedef struct packed {
      logic matched;
      logic overflow;
   } verdict_type;

   // ------------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // DUT
   // ------------------------------------------------------------------------
   logic       req_tvalid = 1'b0;
   wire        req_tready;
   logic [7:0] req_tdata  = 8'd0;   // [7:0] char_in
   logic [1:0] req_tuser  = REQ_CLEAR;   // [1:0] req_type
   wire        rsp_tvalid;
   logic       rsp_tready = 1'b0;
   wire  [7:0] rsp_tdata;           // [0] matched, [1] pattern_overflow, [7:2] zero

   wildcard_glob_matcher_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // ------------------------------------------------------------------------
   // Automaton model: pattern store, length, active set before star closure
   // ------------------------------------------------------------------------
   logic [7:0]     pat_store [PAT_MAX];
   int unsigned    pat_len  = 0;
   logic [PAT_MAX:0] live_set = START_SET;
   logic           pat_ovf  = 1'b0;

   verdict_type   verdict_q [$];
   glob_beat_type pending_q [$];

   int unsigned beats_taken   = 0;
   int unsigned verdicts_seen = 0;
   int unsigned hits_seen     = 0;
   int unsigned ovf_seen      = 0;
   int unsigned fail_count    = 0;
   int unsigned cycle_count   = 0;

   // Let every live star also activate the position after it; walk upward
   // so a run of stars ripples through in one pass.
   function automatic void close_stars();
      for (int i = 0; i < pat_len; i++) begin
         if (live_set[i] && pat_store[i] == CH_STAR)
            live_set[i+1] = 1'b1;
      end
   endfunction

   // Advance the model by one accepted request beat; queue a verdict on
   // end of subject.
   function automatic void glob_step(input logic [1:0] kind, input logic [7:0] ch);
      logic [PAT_MAX:0] nxt;
      nxt = '0;
      case (kind)
         REQ_CLEAR: begin
            pat_len  = 0;
            pat_ovf  = 1'b0;
            live_set = START_SET;
         end
         REQ_APPEND: begin
            if (pat_len < PAT_MAX) begin
               pat_store[pat_len] = ch;
               pat_len++;
            end else begin
               pat_ovf = 1'b1;
            end
            live_set = START_SET;
         end
         REQ_SUBJECT: begin
            close_stars();
            for (int i = 0; i < pat_len; i++) begin
               if (live_set[i]) begin
                  if (pat_store[i] == CH_STAR)
                     nxt[i] = 1'b1;
                  else if (pat_store[i] == CH_QUEST || pat_store[i] == ch)
                     nxt[i+1] = 1'b1;
               end
            end
            live_set = nxt;
         end
         default: begin
            close_stars();
            verdict_q.push_back('{matched: live_set[pat_len], overflow: pat_ovf});
            live_set = START_SET;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   int unsigned gen_count = 0;

   function automatic void push_beat(input logic [1:0] kind, input logic [7:0] ch);
      pending_q.push_back('{kind: kind, ch: ch});
      gen_count++;
   endfunction

   // Small alphabet so random subjects hit literals often.
   function automatic logic [7:0] pick_subject_byte();
      if ($urandom_range(0, 4) == 0)
         return 8'($urandom_range(0, 255));
      return 8'("a") + 8'($urandom_range(0, 2));
   endfunction

   function automatic logic [7:0] pick_pattern_byte();
      case ($urandom_range(0, 9))
         0, 1, 2: return 8'("a");
         3:       return 8'("b");
         4:       return 8'("c");
         5, 6, 8: return CH_STAR;
         7:       return CH_QUEST;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Send one subject: usually an expansion of the pattern so it tends to
   // match, otherwise random; now and then break it with a stray append.
   task automatic send_subject(input logic [7:0] pat [$]);
      logic [7:0] subj [$];
      int unsigned n;
      if ($urandom_range(0, 3) == 0) begin
         n = $urandom_range(0, 8);
         repeat (n) subj.push_back(pick_subject_byte());
      end else begin
         foreach (pat[i]) begin
            if (pat[i] == CH_STAR) begin
               n = $urandom_range(0, 3);
               repeat (n) subj.push_back(pick_subject_byte());
            end else if (pat[i] == CH_QUEST) begin
               subj.push_back(pick_subject_byte());
            end else begin
               subj.push_back(pat[i]);
            end
         end
         // corrupt one byte sometimes
         if (subj.size() > 0 && $urandom_range(0, 5) == 0)
            subj[$urandom_range(0, subj.size() - 1)] = pick_subject_byte();
      end
      foreach (subj[i]) begin
         if ($urandom_range(0, 40) == 0)
            push_beat(REQ_APPEND, pick_pattern_byte());
         push_beat(REQ_SUBJECT, subj[i]);
      end
      push_beat(REQ_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_glob_job(input bit force_overflow);
      logic [7:0] pat [$];
      int unsigned n;
      if (force_overflow)
         n = PAT_MAX + 2;
      else if ($urandom_range(0, 19) == 0)
         n = $urandom_range(PAT_MAX - 1, PAT_MAX + 6);
      else if ($urandom_range(0, 4) == 0)
         n = $urandom_range(9, PAT_MAX);
      else
         n = $urandom_range(0, 8);
      // mostly start fresh; otherwise extend whatever is loaded
      if ($urandom_range(0, 9) != 0)
         push_beat(REQ_CLEAR, 8'($urandom_range(0, 255)));
      repeat (n) begin
         pat.push_back(pick_pattern_byte());
         push_beat(REQ_APPEND, pat[$]);
      end
      n = $urandom_range(1, 3);
      repeat (n) send_subject(pat);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus: directed cases, then random jobs and noise
   // ------------------------------------------------------------------------
   initial begin
      // empty pattern: only the empty subject matches
      push_beat(REQ_CLEAR, 8'h00);
      push_beat(REQ_END, 8'hFF);
      push_beat(REQ_SUBJECT, 8'h00);
      push_beat(REQ_END, 8'h00);
      // byte zero and byte 0xFF as literals
      push_beat(REQ_APPEND, 8'h00);
      push_beat(REQ_APPEND, 8'hFF);
      push_beat(REQ_SUBJECT, 8'h00);
      push_beat(REQ_SUBJECT, 8'hFF);
      push_beat(REQ_END, 8'h00);
      push_beat(REQ_SUBJECT, 8'h00);
      push_beat(REQ_SUBJECT, 8'hFE);
      push_beat(REQ_END, 8'h00);
      // '?' takes one byte, '*' may take none
      push_beat(REQ_CLEAR, 8'hFF);
      push_beat(REQ_APPEND, CH_QUEST);
      push_beat(REQ_APPEND, CH_STAR);
      push_beat(REQ_APPEND, 8'("z"));
      push_beat(REQ_SUBJECT, 8'("q"));
      push_beat(REQ_SUBJECT, 8'("z"));
      push_beat(REQ_END, 8'h00);
      push_beat(REQ_SUBJECT, 8'("z"));
      push_beat(REQ_END, 8'h00);
      // append mid-subject drops the subject so far
      push_beat(REQ_SUBJECT, 8'("q"));
      push_beat(REQ_APPEND, CH_STAR);
      push_beat(REQ_END, 8'h00);

      // random part; the first job overflows the pattern store
      send_glob_job(1'b1);
      while (gen_count < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8))
               push_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end else begin
            send_glob_job(1'b0);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // drain: everything sent, every verdict back, then settle
      while (pending_q.size() != 0 || req_tvalid) @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d request beats; checked %0d verdicts (%0d matched, %0d with overflow).",
               beats_taken, verdicts_seen, hits_seen, ovf_seen);
      if (fail_count == 0 && verdict_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Request driver: bursts of random length, random gaps between them
   // ------------------------------------------------------------------------
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin
      glob_beat_type nb;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         // current beat is done or none is up: advance
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_q.size() != 0) begin
            nb = pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= nb.kind;
            req_tdata  <= nb.ch;
            burst_left--;
            if (burst_left == 0) begin
               // long bursts now and then give stretches with no idling
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                        : $urandom_range(1, 20);
               gap_left   = $urandom_range(0, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Update the model on every accepted request beat.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         glob_step(req_tuser, req_tdata);
         beats_taken++;
      end
   end

   // ------------------------------------------------------------------------
   // Response receiver: rotating stall pattern plus one long hold-off
   // ------------------------------------------------------------------------
   int unsigned hold_left  = 0;
   bit          hold_done  = 1'b0;
   logic [7:0]  stall_tick = '0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && beats_taken >= HOLD_AFTER) begin
         // hold off long enough for the block to back up and stall requests
         hold_done = 1'b1;
         hold_left = HOLD_LEN;
         rsp_tready <= 1'b0;
      end else begin
         stall_tick++;
         case (stall_tick[7:6])
            2'd0:    rsp_tready <= 1'b1;
            2'd1:    rsp_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    rsp_tready <= stall_tick[0];
            default: rsp_tready <= ($urandom_range(0, 2) == 0);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: compare each beat with the oldest verdict
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_q.size() == 0) begin
            $display("%0t: unexpected response beat, expected none, actual tdata=%h",
                     $time, rsp_tdata);
            fail_count++;
         end else begin
            want = verdict_q.pop_front();
            verdicts_seen++;
            if (want.matched) hits_seen++;
            if (want.overflow) ovf_seen++;
            if (rsp_tdata[0] !== want.matched) begin
               $display("%0t: matched mismatch, expected %b actual %b",
                        $time, want.matched, rsp_tdata[0]);
               fail_count++;
            end
            if (rsp_tdata[1] !== want.overflow) begin
               $display("%0t: pattern_overflow mismatch, expected %b actual %b",
                        $time, want.overflow, rsp_tdata[1]);
               fail_count++;
            end
            if (rsp_tdata[7:2] !== 6'd0) begin
               $display("%0t: pad bits mismatch, expected %h actual %h",
                        $time, 6'd0, rsp_tdata[7:2]);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d verdicts outstanding",
                  $time, cycle_count, verdict_q.size());
         $display("Verification failed");
         $finish;
      end
   end

endmodule

`default_nettype wire
